// ===== sv/nbsc_pkg.sv =====
// Naive Bayes spam classifier: shared types, constants and the log2 table.
// No dependencies; imported by every module of the block except nbsc_ram.
package nbsc_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int LOG_TAB_BITS   = 8;
  localparam int LOG_SIZE       = 1 << LOG_TAB_BITS;
  localparam int VOCAB_SIZE_DEF = 1024;
  localparam int IDX_W          = 10;
  localparam int FREQ_W         = 16;
  localparam int CNT_W          = 32;
  localparam int MARGIN_W       = 20;
  localparam int MARGIN_FRAC    = 16;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = 20'd45875;

  localparam int LN_XW  = CNT_W + 1;
  localparam int LN_PW  = 6;
  localparam int LN_W   = LN_PW + FRAC_BITS;
  localparam int RAT_W  = LN_W + 1;
  localparam int TERM_W = FREQ_W + 1 + RAT_W;
  localparam int ACC_W  = 48;
  localparam int THR_W  = MARGIN_W + CNT_W;

  localparam logic [63:0] LN2_Q   = ((64'd2977044472 >> (31 - FRAC_BITS)) + 64'd1) >> 1;
  localparam logic [63:0] LNMIN_Q = (((64'd386309675 << 1) >> (24 - FRAC_BITS)) + 64'd1) >> 1;
  localparam int MSHL = (FRAC_BITS >= MARGIN_FRAC) ? FRAC_BITS - MARGIN_FRAC : 0;
  localparam int MSHR = (FRAC_BITS >= MARGIN_FRAC) ? 0 : MARGIN_FRAC - FRAC_BITS;

  typedef enum logic {
    CMD_TRAIN    = 1'b0,
    CMD_CLASSIFY = 1'b1
  } nbsc_cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRAIN,
    ST_TERM_S,
    ST_TERM_H,
    ST_PRIOR_S,
    ST_PRIOR_H,
    ST_WAIT,
    ST_THR,
    ST_OUT
  } nbsc_state_e;

  typedef struct packed {
    logic              command;
    logic              is_spam_label;
    logic [IDX_W-1:0]  word_index;
    logic [FREQ_W-1:0] frequency;
    logic              last_of_message;
  } nbsc_in_t;

  typedef struct packed {
    logic             verdict_spam;
    logic [CNT_W-1:0] word_total;
  } nbsc_out_t;

  // one log-ratio pass into the scoring pipeline
  typedef struct packed {
    logic              vld;
    logic              spam;
    logic              zero;
    logic [FREQ_W-1:0] mult;
    logic [LN_XW-1:0]  num;
    logic [LN_XW-1:0]  den;
  } nbsc_req_t;

  typedef struct packed {
    logic              vld;
    logic              spam;
    logic              zero;
    logic [FREQ_W-1:0] mult;
  } nbsc_tag_t;

  typedef logic [FRAC_BITS-1:0] log_tab_t [LOG_SIZE];

  function automatic log_tab_t build_log_tab();
    log_tab_t              t;
    logic [63:0]           m;
    logic [FRAC_BITS-1:0]  r;
    for (int i = 0; i < LOG_SIZE; i++) begin
      m = (64'd1 << 30) + (64'(i) << (30 - LOG_TAB_BITS));
      r = '0;
      for (int k = 0; k < FRAC_BITS; k++) begin
        m = (m * m) >> 30;
        r = {r[FRAC_BITS-2:0], 1'b0};
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          r[0] = 1'b1;
        end
      end
      t[i] = r;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] s);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

// ===== sv/nbsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module nbsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/nbsc_ln.sv =====
// Two-stage natural log unit: leading one plus table log2, then scale by ln2.
// Depends on nbsc_pkg.
module nbsc_ln import nbsc_pkg::*; (
  input  logic             clk_i,
  input  logic [LN_XW-1:0] x_i,
  output logic [LN_W-1:0]  ln_o
);

  logic [LN_PW-1:0]        p;
  logic [LN_XW-1:0]        norm;
  logic [LOG_TAB_BITS-1:0] idx;
  logic [LN_W-1:0]         l2_d, l2_q;
  logic [LN_W+FRAC_BITS:0] prod;
  logic [LN_W-1:0]         ln_d, ln_q;

  always_comb begin
    p = '0;
    for (int i = 0; i < LN_XW; i++) begin
      if (x_i[i]) p = LN_PW'(i);
    end
    norm = x_i << (LN_PW'(LN_XW - 1) - p);
    idx  = norm[LN_XW-2 -: LOG_TAB_BITS];
    l2_d = (x_i == '0) ? '0 : {p, LOG_TAB[idx]};
  end

  always_comb begin
    prod = (LN_W+FRAC_BITS+1)'(l2_q) * (LN_W+FRAC_BITS+1)'(LN2_Q[FRAC_BITS-1:0])
         + (LN_W+FRAC_BITS+1)'(1 << (FRAC_BITS - 1));
    ln_d = LN_W'(prod >> FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    l2_q <= l2_d;
    ln_q <= ln_d;
  end

  assign ln_o = ln_q;

endmodule

// ===== sv/nbsc_score.sv =====
// Scoring pipeline: log ratio, clamp, frequency weight and class accumulators.
// Depends on nbsc_pkg and nbsc_ln.
module nbsc_score import nbsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  nbsc_req_t               req_i,
  input  logic                    clr_i,
  output logic signed [ACC_W-1:0] spam_acc_o,
  output logic signed [ACC_W-1:0] ham_acc_o
);

  localparam logic signed [RAT_W-1:0] NEG_LNMIN = -$signed(RAT_W'(LNMIN_Q));

  nbsc_tag_t                tag1_q, tag2_q, tag3_q;
  nbsc_tag_t                tag1_d;
  logic [LN_W-1:0]          ln_num, ln_den;
  logic signed [RAT_W-1:0]  diff, ratio;
  logic signed [TERM_W-1:0] term_d, term_q;
  logic signed [ACC_W-1:0]  spam_acc_q, ham_acc_q, spam_acc_d, ham_acc_d;
  logic signed [ACC_W:0]    sum;

  nbsc_ln u_ln_num (.clk_i(clk_i), .x_i(req_i.num), .ln_o(ln_num));
  nbsc_ln u_ln_den (.clk_i(clk_i), .x_i(req_i.den), .ln_o(ln_den));

  assign tag1_d = '{vld: req_i.vld, spam: req_i.spam, zero: req_i.zero, mult: req_i.mult};

  always_comb begin
    diff   = $signed({1'b0, ln_num}) - $signed({1'b0, ln_den});
    ratio  = (tag2_q.zero || diff < NEG_LNMIN) ? NEG_LNMIN : diff;
    term_d = TERM_W'($signed({1'b0, tag2_q.mult}) * ratio);
  end

  always_comb begin
    spam_acc_d = spam_acc_q;
    ham_acc_d  = ham_acc_q;
    sum = (tag3_q.spam ? {spam_acc_q[ACC_W-1], spam_acc_q} : {ham_acc_q[ACC_W-1], ham_acc_q})
        + (ACC_W+1)'(term_q);
    if (clr_i) begin
      spam_acc_d = '0;
      ham_acc_d  = '0;
    end else if (tag3_q.vld) begin
      if (tag3_q.spam) spam_acc_d = sat_acc(sum);
      else             ham_acc_d  = sat_acc(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q     <= '0;
      tag2_q     <= '0;
      tag3_q     <= '0;
      spam_acc_q <= '0;
      ham_acc_q  <= '0;
    end else begin
      tag1_q     <= tag1_d;
      tag2_q     <= tag1_q;
      tag3_q     <= tag2_q;
      spam_acc_q <= spam_acc_d;
      ham_acc_q  <= ham_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign spam_acc_o = spam_acc_q;
  assign ham_acc_o  = ham_acc_q;

endmodule

// ===== sv/naive_bayes_spam_classifier.sv =====
// Naive Bayes spam classifier top level: sequencer, count memory, totals.
// Depends on nbsc_pkg, nbsc_ram and nbsc_score.
//
// Input words carry one (word, frequency) element; a word is taken when
// in_valid_i is high and in_stall_o low. Training elements update the
// spam/ham word counts held in one 64-bit wide count RAM (read, add,
// write back) and the class totals; the last element counts the message.
// Classify elements run two log-ratio passes through the scoring pipeline.
// A new word is not taken until the sequencer is back in ST_IDLE; an
// element with an unknown word index does no count RAM access. The
// count RAM read and the read-modify-write of its entry set the pace.
// The last classify element adds two prior passes, drains the 4-stage
// scoring pipeline and forms the threshold: the verdict word is loaded
// into the output register in ST_OUT once the output register is free.
// After reset a clearing pass sets every count to one;
// no word is taken meanwhile. Configuration writes are taken at any time.
// While the receiver stalls, the result holds in the output register and
// further words are still taken until the next result is ready.
module naive_bayes_spam_classifier import nbsc_pkg::*; #(
  parameter int VOCAB_SIZE = VOCAB_SIZE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nbsc_in_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nbsc_out_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [MARGIN_W-1:0] cfg_wdata_i
);

  localparam int AW = $clog2(VOCAB_SIZE);
  localparam logic [CNT_W-1:0] TOT_RST = CNT_W'((3 * VOCAB_SIZE) / 2);
  localparam logic [2*CNT_W-1:0] CNT_ONES = {CNT_W'(1), CNT_W'(1)};

  nbsc_state_e state_q, state_d;
  logic [AW-1:0]       clr_q;
  nbsc_in_t            item_q;
  logic [MARGIN_W-1:0] margin_q;
  logic [CNT_W-1:0]    spam_tot_q, ham_tot_q, spam_msg_q, ham_msg_q, words_q;
  logic [CNT_W-1:0]    ham_cnt_q;
  logic [1:0]          wait_q;
  logic [63:0]         thr_q, thr_d;
  logic                out_valid_q;
  nbsc_out_t           out_q;

  logic                accept, idx_ok, out_free, out_load, acc_clr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [2*CNT_W-1:0]  ram_wdata, ram_rdata;
  nbsc_req_t           req;
  logic [LN_XW-1:0]    msg_sum;
  logic [CNT_W-1:0]    n;
  logic [THR_W-1:0]    thr_prod;
  logic signed [ACC_W-1:0] spam_acc, ham_acc;
  logic                verdict;

  assign accept   = in_valid_i && !in_stall_o;
  assign idx_ok   = 32'(in_word_i.word_index) < 32'(VOCAB_SIZE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign msg_sum  = {1'b0, spam_msg_q} + {1'b0, ham_msg_q};

  nbsc_ram #(.WIDTH(2 * CNT_W), .DEPTH(VOCAB_SIZE)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(AW'(in_word_i.word_index)),
    .rdata_o(ram_rdata)
  );

  nbsc_score u_score (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .clr_i     (acc_clr),
    .spam_acc_o(spam_acc),
    .ham_acc_o (ham_acc)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(VOCAB_SIZE - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_word_i.command == CMD_TRAIN) begin
            state_d = idx_ok ? ST_TRAIN : ST_IDLE;
          end else if (idx_ok) begin
            state_d = ST_TERM_S;
          end else begin
            state_d = in_word_i.last_of_message ? ST_PRIOR_S : ST_IDLE;
          end
        end
      end
      ST_TRAIN:   state_d = ST_IDLE;
      ST_TERM_S:  state_d = ST_TERM_H;
      ST_TERM_H:  state_d = item_q.last_of_message ? ST_PRIOR_S : ST_IDLE;
      ST_PRIOR_S: state_d = ST_PRIOR_H;
      ST_PRIOR_H: state_d = ST_WAIT;
      ST_WAIT: begin
        if (wait_q == 2'd0) state_d = ST_THR;
      end
      ST_THR:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:    state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    ram_waddr  = clr_q;
    ram_wdata  = CNT_ONES;
    req        = '0;
    acc_clr    = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE:  in_stall_o = 1'b0;
      ST_TRAIN: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(item_q.word_index);
        if (item_q.is_spam_label) begin
          ram_wdata = {sat_add32(ram_rdata[2*CNT_W-1:CNT_W], CNT_W'(item_q.frequency)),
                       ram_rdata[CNT_W-1:0]};
        end else begin
          ram_wdata = {ram_rdata[2*CNT_W-1:CNT_W],
                       sat_add32(ram_rdata[CNT_W-1:0], CNT_W'(item_q.frequency))};
        end
      end
      ST_TERM_S: req = '{vld: 1'b1, spam: 1'b1, zero: 1'b0, mult: item_q.frequency,
                         num: LN_XW'(ram_rdata[2*CNT_W-1:CNT_W]),
                         den: LN_XW'(spam_tot_q)};
      ST_TERM_H: req = '{vld: 1'b1, spam: 1'b0, zero: 1'b0, mult: item_q.frequency,
                         num: LN_XW'(ham_cnt_q), den: LN_XW'(ham_tot_q)};
      ST_PRIOR_S: req = '{vld: 1'b1, spam: 1'b1, zero: (spam_msg_q == '0),
                          mult: FREQ_W'(1), num: LN_XW'(spam_msg_q), den: msg_sum};
      ST_PRIOR_H: req = '{vld: 1'b1, spam: 1'b0, zero: (ham_msg_q == '0),
                          mult: FREQ_W'(1), num: LN_XW'(ham_msg_q), den: msg_sum};
      ST_OUT: begin
        out_load = out_free;
        acc_clr  = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    n        = (words_q == '0) ? CNT_W'(1) : words_q;
    thr_prod = THR_W'(margin_q) * THR_W'(n);
    thr_d    = (64'(thr_prod) << MSHL) >> MSHR;
    verdict  = 64'(spam_acc) > (64'(ham_acc) + $signed(thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      margin_q    <= MARGIN_RST;
      spam_tot_q  <= TOT_RST;
      ham_tot_q   <= TOT_RST;
      spam_msg_q  <= '0;
      ham_msg_q   <= '0;
      words_q     <= '0;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      if (cfg_we_i) margin_q <= cfg_wdata_i;
      if (accept) begin
        if (in_word_i.command == CMD_TRAIN) begin
          if (idx_ok) begin
            if (in_word_i.is_spam_label) begin
              spam_tot_q <= sat_add32(spam_tot_q, CNT_W'(in_word_i.frequency));
            end else begin
              ham_tot_q <= sat_add32(ham_tot_q, CNT_W'(in_word_i.frequency));
            end
          end
          if (in_word_i.last_of_message) begin
            if (in_word_i.is_spam_label) spam_msg_q <= sat_add32(spam_msg_q, CNT_W'(1));
            else                         ham_msg_q  <= sat_add32(ham_msg_q, CNT_W'(1));
          end
        end else if (idx_ok) begin
          words_q <= sat_add32(words_q, CNT_W'(in_word_i.frequency));
        end
      end
      if (state_q == ST_PRIOR_H) wait_q <= 2'd2;
      else if (state_q == ST_WAIT) wait_q <= wait_q - 2'd1;
      if (out_load) begin
        words_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_word_i;
    if (state_q == ST_TERM_S) ham_cnt_q <= ram_rdata[CNT_W-1:0];
    if (state_q == ST_THR) thr_q <= thr_d;
    if (out_load) out_q <= '{verdict_spam: verdict, word_total: words_q};
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== sv/nbsc_chk.sv =====
// Port-level checker for the spam classifier, bound to the top level.
// Depends on nbsc_pkg.
module nbsc_chk import nbsc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input nbsc_in_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input nbsc_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o))
    else $error("result word changed while stalled");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_word_i.command == CMD_CLASSIFY
     && in_word_i.last_of_message) |=> in_stall_o)
    else $error("input taken straight after final classify word");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy sequencer");

endmodule

bind naive_bayes_spam_classifier nbsc_chk u_nbsc_chk (.*);
